@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the piecewise linear curve block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PWLC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PWLC_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PWLC_ASSERT(label, clk, rst_n, prop, msg)

`define PWLC_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/pwlc_pkg.sv @@
// Types and codes shared by the piecewise linear curve modules.
`default_nettype none

package pwlc_pkg;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		REGION_EMPTY     = 3'd0,
		REGION_BELOW     = 3'd1,
		REGION_ABOVE     = 3'd2,
		REGION_INTERP    = 3'd3,
		REGION_ZERO_SPAN = 3'd4,
		REGION_NO_SEG    = 3'd5,
		REGION_WRITE_ACK = 3'd6
	} region_t;

	typedef struct packed {
		logic               kind;
		logic [3:0]         point_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] query_x;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_y;
		region_t            region;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} point_t;

	typedef enum logic [1:0] {
		RD_FIRST,
		RD_LAST,
		RD_IDX
	} rd_sel_t;

	typedef enum logic [1:0] {
		Y_ZERO,
		Y_RD,
		Y_PREV,
		Y_INTERP
	} y_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FIRST,
		ST_LAST,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    wr;
		logic    rd;
		rd_sel_t rd_sel;
		logic    save_prev;
		logic    idx_init;
		logic    idx_inc;
		logic    div_start;
		logic    mul;
		logic    emit;
		region_t region;
		y_sel_t  y_sel;
	} cmd_t;

	typedef struct packed {
		logic is_lookup;
		logic n_zero;
		logic q_le_x;
		logic q_ge_x;
		logic span_pos;
		logic idx_last;
		logic div_done;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/pwlc_div.sv @@
// Bit-serial restoring divider producing the interpolation fraction.
`default_nettype none

module pwlc_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [32:0]          dividend,
	input  wire logic [32:0]          divisor,
	output logic                      done,
	output logic [FRAC_BITS:0]        quotient
);

	localparam int CW = $clog2(FRAC_BITS + 2);

	logic [33:0]        rem_q;
	logic [32:0]        den_q;
	logic [FRAC_BITS:0] quo_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               ge;
	logic [33:0]        diff;
	logic [33:0]        rem_next;

	assign diff     = rem_q - {1'b0, den_q};
	assign ge       = rem_q >= {1'b0, den_q};
	assign rem_next = ge ? diff : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(FRAC_BITS + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_next[32:0], 1'b0};
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ rtl/pwlc_dp.sv @@
// Datapath: breakpoint memory, segment registers, divider, multiplier and result register.
`default_nettype none

module pwlc_dp #(
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pwlc_pkg::in_word_t item,
	input  wire logic              cfg_we,
	input  wire logic [4:0]        cfg_wdata,
	input  wire pwlc_pkg::cmd_t    cmd,
	output pwlc_pkg::sts_t         sts,
	output pwlc_pkg::out_word_t    result,
	output logic                   done
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NW = $clog2(MAX_POINTS + 1);

	pwlc_pkg::point_t    mem [MAX_POINTS];
	pwlc_pkg::in_word_t  item_q;
	pwlc_pkg::point_t    rd_q;
	pwlc_pkg::point_t    prev_q;
	pwlc_pkg::out_word_t result_q;
	logic                done_q;
	logic [4:0]          count_q;
	logic [AW-1:0]       idx_q;
	logic [NW-1:0]       n_eff;
	logic [AW-1:0]       last_addr;
	logic [AW-1:0]       rd_addr;
	logic signed [32:0]  dy_q;
	logic signed [FRAC_BITS+34:0] prod_q;
	logic signed [FRAC_BITS+34:0] prod_sh;
	logic [32:0]         div_num;
	logic [32:0]         div_den;
	logic [FRAC_BITS:0]  t;
	logic                div_done;
	logic signed [31:0]  interp_y;
	pwlc_pkg::out_word_t out_d;

	assign n_eff = (32'(count_q) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(count_q);
	assign last_addr = AW'(n_eff - NW'(1));

	always_comb begin
		case (cmd.rd_sel)
			pwlc_pkg::RD_FIRST: rd_addr = '0;
			pwlc_pkg::RD_LAST:  rd_addr = last_addr;
			pwlc_pkg::RD_IDX:   rd_addr = idx_q;
			default:            rd_addr = idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && (32'(item_q.point_index) < 32'(MAX_POINTS))) begin
			mem[AW'(item_q.point_index)] <= '{x: item_q.point_x, y: item_q.point_y};
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign div_num = {item_q.query_x[31], item_q.query_x} - {prev_q.x[31], prev_q.x};
	assign div_den = {rd_q.x[31], rd_q.x} - {prev_q.x[31], prev_q.x};

	pwlc_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(div_num),
		.divisor (div_den),
		.done    (div_done),
		.quotient(t)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.save_prev) begin
			prev_q <= rd_q;
		end
		if (cmd.idx_init) begin
			idx_q <= AW'(1);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
		if (cmd.div_start) begin
			dy_q <= $signed({rd_q.y[31], rd_q.y} - {prev_q.y[31], prev_q.y});
		end
		if (cmd.mul) begin
			prod_q <= dy_q * $signed({1'b0, t});
		end
		if (cmd.emit) begin
			result_q <= out_d;
		end
	end

	assign prod_sh  = prod_q >>> FRAC_BITS;
	assign interp_y = prev_q.y + prod_sh[31:0];

	always_comb begin
		out_d.region = cmd.region;
		case (cmd.y_sel)
			pwlc_pkg::Y_ZERO:   out_d.result_y = '0;
			pwlc_pkg::Y_RD:     out_d.result_y = rd_q.y;
			pwlc_pkg::Y_PREV:   out_d.result_y = prev_q.y;
			pwlc_pkg::Y_INTERP: out_d.result_y = interp_y;
			default:            out_d.result_y = '0;
		endcase
	end

	assign sts.is_lookup = (item_q.kind == pwlc_pkg::KIND_LOOKUP);
	assign sts.n_zero    = (n_eff == '0);
	assign sts.q_le_x    = (item_q.query_x <= rd_q.x);
	assign sts.q_ge_x    = (item_q.query_x >= rd_q.x);
	assign sts.span_pos  = (rd_q.x > prev_q.x);
	assign sts.idx_last  = (idx_q == last_addr);
	assign sts.div_done  = div_done;

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

@@ rtl/pwlc_ctrl.sv @@
// Controller state machine sequencing table access, segment search and interpolation.
`default_nettype none

module pwlc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire pwlc_pkg::sts_t sts,
	output pwlc_pkg::cmd_t      cmd,
	output logic                busy
);

	pwlc_pkg::state_t state_q;
	pwlc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwlc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pwlc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = pwlc_pkg::ST_DECODE;
				end
			end
			pwlc_pkg::ST_DECODE: begin
				if (!sts.is_lookup || sts.n_zero) begin
					state_d = pwlc_pkg::ST_IDLE;
				end else begin
					state_d = pwlc_pkg::ST_FIRST;
				end
			end
			pwlc_pkg::ST_FIRST: begin
				state_d = sts.q_le_x ? pwlc_pkg::ST_IDLE : pwlc_pkg::ST_LAST;
			end
			pwlc_pkg::ST_LAST: begin
				state_d = sts.q_ge_x ? pwlc_pkg::ST_IDLE : pwlc_pkg::ST_SCAN_RD;
			end
			pwlc_pkg::ST_SCAN_RD: begin
				state_d = pwlc_pkg::ST_SCAN_CHK;
			end
			pwlc_pkg::ST_SCAN_CHK: begin
				if (sts.q_le_x) begin
					state_d = sts.span_pos ? pwlc_pkg::ST_DIV : pwlc_pkg::ST_IDLE;
				end else if (sts.idx_last) begin
					state_d = pwlc_pkg::ST_IDLE;
				end else begin
					state_d = pwlc_pkg::ST_SCAN_RD;
				end
			end
			pwlc_pkg::ST_DIV: begin
				if (sts.div_done) begin
					state_d = pwlc_pkg::ST_MUL;
				end
			end
			pwlc_pkg::ST_MUL: begin
				state_d = pwlc_pkg::ST_OUT;
			end
			pwlc_pkg::ST_OUT: begin
				state_d = pwlc_pkg::ST_IDLE;
			end
			default: begin
				state_d = pwlc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = pwlc_pkg::RD_IDX;
		cmd.region = pwlc_pkg::REGION_EMPTY;
		cmd.y_sel  = pwlc_pkg::Y_ZERO;
		case (state_q)
			pwlc_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			pwlc_pkg::ST_DECODE: begin
				if (!sts.is_lookup) begin
					cmd.wr     = 1'b1;
					cmd.emit   = 1'b1;
					cmd.region = pwlc_pkg::REGION_WRITE_ACK;
				end else if (sts.n_zero) begin
					cmd.emit   = 1'b1;
					cmd.region = pwlc_pkg::REGION_EMPTY;
				end else begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = pwlc_pkg::RD_FIRST;
				end
			end
			pwlc_pkg::ST_FIRST: begin
				cmd.save_prev = 1'b1;
				if (sts.q_le_x) begin
					cmd.emit   = 1'b1;
					cmd.region = pwlc_pkg::REGION_BELOW;
					cmd.y_sel  = pwlc_pkg::Y_RD;
				end else begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = pwlc_pkg::RD_LAST;
				end
			end
			pwlc_pkg::ST_LAST: begin
				if (sts.q_ge_x) begin
					cmd.emit   = 1'b1;
					cmd.region = pwlc_pkg::REGION_ABOVE;
					cmd.y_sel  = pwlc_pkg::Y_RD;
				end else begin
					cmd.idx_init = 1'b1;
				end
			end
			pwlc_pkg::ST_SCAN_RD: begin
				cmd.rd = 1'b1;
			end
			pwlc_pkg::ST_SCAN_CHK: begin
				if (sts.q_le_x) begin
					if (sts.span_pos) begin
						cmd.div_start = 1'b1;
					end else begin
						cmd.emit   = 1'b1;
						cmd.region = pwlc_pkg::REGION_ZERO_SPAN;
						cmd.y_sel  = pwlc_pkg::Y_PREV;
					end
				end else if (sts.idx_last) begin
					cmd.emit   = 1'b1;
					cmd.region = pwlc_pkg::REGION_NO_SEG;
					cmd.y_sel  = pwlc_pkg::Y_RD;
				end else begin
					cmd.save_prev = 1'b1;
					cmd.idx_inc   = 1'b1;
				end
			end
			pwlc_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
			end
			pwlc_pkg::ST_OUT: begin
				cmd.emit   = 1'b1;
				cmd.region = pwlc_pkg::REGION_INTERP;
				cmd.y_sel  = pwlc_pkg::Y_INTERP;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != pwlc_pkg::ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/piecewise_linear_curve.sv @@
// Top level of the piecewise linear curve interpolator.
//
// A word on item is taken at a clock edge where start is high and busy is low.
// A write word (kind 0) stores one breakpoint; a lookup word (kind 1) returns
// a y for query_x in signed fixed point, interpolated between two breakpoints when query_x lies inside the table.
// Every word gives exactly one result word on result, marked by done for one
// cycle; the receiver cannot stall, so each result must be taken when shown.
// The point count register is written through cfg_we and cfg_wdata; the user
// must do so only while idle, as the block itself does not enforce this.
// Lookup time is set by the single read port of the breakpoint memory, scanned
// one entry per ST_SCAN_RD/ST_SCAN_CHK pass, and by the bit-serial divider, one
// quotient bit per cycle. One word is in work at a time; busy stays high until
// it is done. Reset clears the point count and the controller; table entries
// hold nothing defined until written.
`default_nettype none
`include "assert_macros.svh"

module piecewise_linear_curve #(
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire pwlc_pkg::in_word_t item,
	input  wire logic               cfg_we,
	input  wire logic [4:0]         cfg_wdata,
	output logic                    done,
	output pwlc_pkg::out_word_t     result
);

	pwlc_pkg::cmd_t cmd;
	pwlc_pkg::sts_t sts;

	pwlc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	pwlc_dp #(
		.MAX_POINTS(MAX_POINTS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result),
		.done     (done)
	);

	`PWLC_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "accepted word did not raise busy")
	`PWLC_NEVER(a_done_after_accept, clk, arst_n, done && $past(start && !busy), "result one cycle after accept")
	`PWLC_ASSERT(a_done_single, clk, arst_n, done |=> !done, "two result words in consecutive cycles")

endmodule

`default_nettype wire
